### sv/aabb_frustum_cull_test_defines.svh
// Assertion macros shared by the box culling RTL.
`ifndef AABB_FRUSTUM_CULL_TEST_DEFINES_SVH
`define AABB_FRUSTUM_CULL_TEST_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define AFCT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define AFCT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define AFCT_ASSERT(label, clk, rst, prop, msg)
`define AFCT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### sv/afct_pkg.sv
// Types and constants shared by the box culling modules.
`default_nettype none

package afct_pkg;

  localparam int IDX_W        = 3;
  localparam int DATA_W       = 32;
  localparam int EXT_W        = 31;
  localparam int MAG_PROD_W   = 63;   // |normal| * extent
  localparam int SGN_PROD_W   = 64;   // normal * center
  localparam int RSUM_W       = 65;   // sum of three radius terms
  localparam int DSUM_W       = 66;   // three distance terms plus scaled offset
  localparam int TOT_W        = 67;   // radius + distance
  localparam int OFFSET_SHIFT = 30;   // Q16.16 offset to Q18.46

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       operation;
    logic [IDX_W-1:0]          plane_index;
    logic signed [DATA_W-1:0]  normal_x;
    logic signed [DATA_W-1:0]  normal_y;
    logic signed [DATA_W-1:0]  normal_z;
    logic signed [DATA_W-1:0]  plane_offset;
    logic signed [DATA_W-1:0]  center_x;
    logic signed [DATA_W-1:0]  center_y;
    logic signed [DATA_W-1:0]  center_z;
    logic [EXT_W-1:0]          extent_x;
    logic [EXT_W-1:0]          extent_y;
    logic [EXT_W-1:0]          extent_z;
  } item_t;

  // One slot of the cell chain: an item and whether it still survives.
  typedef struct packed {
    logic  valid;
    logic  vis;
    item_t item;
  } lane_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] nx;
    logic signed [DATA_W-1:0] ny;
    logic signed [DATA_W-1:0] nz;
    logic signed [DATA_W-1:0] w;
  } plane_t;

endpackage

`default_nettype wire

### sv/afct_channels.sv
// Handshake channels for box culling commands and results.
`default_nettype none

interface afct_cmd_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [2:0]         plane_index;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;
  logic signed [31:0] plane_offset;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        extent_x;
  logic [30:0]        extent_y;
  logic [30:0]        extent_z;

  modport source (
    output valid, operation, plane_index, normal_x, normal_y, normal_z, plane_offset,
           center_x, center_y, center_z, extent_x, extent_y, extent_z,
    input  ready
  );
  modport sink (
    input  valid, operation, plane_index, normal_x, normal_y, normal_z, plane_offset,
           center_x, center_y, center_z, extent_x, extent_y, extent_z,
    output ready
  );
endinterface

interface afct_result_if;
  logic valid;
  logic ready;
  logic was_test;
  logic visible;

  modport source (output valid, was_test, visible, input ready);
  modport sink (input valid, was_test, visible, output ready);
endinterface

`default_nettype wire

### sv/afct_cell.sv
// One plane of the culling chain: stores the plane and tests passing boxes against it.
`default_nettype none

module afct_cell #(
  parameter int INDEX = 0
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              adv,
  input  wire afct_pkg::lane_t lane_in,
  output afct_pkg::lane_t  lane_out
);
  import afct_pkg::*;

  plane_t plane;

  // stage 1: products
  lane_t                          s1;
  logic [MAG_PROD_W-1:0]          p_rx, p_ry, p_rz;
  logic signed [SGN_PROD_W-1:0]   p_dx, p_dy, p_dz;
  logic signed [DATA_W-1:0]       p_w;

  // stage 2: partial sums
  lane_t                          s2;
  logic [RSUM_W-1:0]              rsum;
  logic signed [DSUM_W-1:0]       dsum;

  logic [DATA_W-1:0]              mag_x, mag_y, mag_z;
  logic signed [DSUM_W-1:0]       w_ext;
  logic signed [TOT_W-1:0]        total;
  logic                           load_here;

  assign load_here = lane_in.valid && (lane_in.item.operation == OP_LOAD)
                     && (lane_in.item.plane_index == IDX_W'(INDEX));

  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
    end else if (adv && load_here) begin
      plane.nx <= lane_in.item.normal_x;
      plane.ny <= lane_in.item.normal_y;
      plane.nz <= lane_in.item.normal_z;
      plane.w  <= lane_in.item.plane_offset;
    end
  end

  always_comb begin
    mag_x = plane.nx[DATA_W-1] ? DATA_W'(-plane.nx) : DATA_W'(plane.nx);
    mag_y = plane.ny[DATA_W-1] ? DATA_W'(-plane.ny) : DATA_W'(plane.ny);
    mag_z = plane.nz[DATA_W-1] ? DATA_W'(-plane.nz) : DATA_W'(plane.nz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (adv) begin
      s1   <= lane_in;
      p_rx <= MAG_PROD_W'(mag_x) * MAG_PROD_W'(lane_in.item.extent_x);
      p_ry <= MAG_PROD_W'(mag_y) * MAG_PROD_W'(lane_in.item.extent_y);
      p_rz <= MAG_PROD_W'(mag_z) * MAG_PROD_W'(lane_in.item.extent_z);
      p_dx <= SGN_PROD_W'(plane.nx) * SGN_PROD_W'(lane_in.item.center_x);
      p_dy <= SGN_PROD_W'(plane.ny) * SGN_PROD_W'(lane_in.item.center_y);
      p_dz <= SGN_PROD_W'(plane.nz) * SGN_PROD_W'(lane_in.item.center_z);
      p_w  <= plane.w;
    end
  end

  assign w_ext = DSUM_W'(p_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (adv) begin
      s2   <= s1;
      rsum <= RSUM_W'(p_rx) + RSUM_W'(p_ry) + RSUM_W'(p_rz);
      dsum <= DSUM_W'(p_dx) + DSUM_W'(p_dy) + DSUM_W'(p_dz) + (w_ext <<< OFFSET_SHIFT);
    end
  end

  // Cull when distance + radius goes negative; an exact zero survives.
  assign total = $signed({2'b00, rsum}) + TOT_W'(dsum);

  always_comb begin
    lane_out = s2;
    if (s2.item.operation == OP_TEST) begin
      lane_out.vis = s2.vis && !total[TOT_W-1];
    end
  end

endmodule

`default_nettype wire

### sv/aabb_frustum_cull_test.sv
// Top level of the box versus frustum plane culling test.
`default_nettype none
`include "aabb_frustum_cull_test_defines.svh"

// Box culling against a table of PLANE_COUNT frustum planes. Each command item
// either loads one plane (normal Q2.30, offset Q16.16) or tests one box
// (center and half extents in Q16.16); every item returns exactly one result,
// with was_test low for a load. The planes live in a chain of PLANE_COUNT
// cells; items walk the chain one stage per cycle unless stalled, and a load
// writes its plane when it reaches its own cell, so loads and tests keep their
// order. A new item is taken every cycle while the result side keeps up; the
// first stall on the result side holds the whole chain. Each item passes the
// input register, two stages per cell for the products and the sums, and the
// output register. Loads to a slot at or above PLANE_COUNT are dropped; all
// planes read as zero after reset.
module aabb_frustum_cull_test #(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_WIDTH = 32
) (
  input wire             clk,
  input wire             rst,
  afct_cmd_if.sink       cmd,
  afct_result_if.source  result
);
  import afct_pkg::*;

  localparam int CSH = DATA_W - COORD_WIDTH;
  localparam logic [EXT_W-1:0] EXT_MASK = EXT_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);

  lane_t                    chain [PLANE_COUNT+1];
  logic [PLANE_COUNT:0]     lane_valid;
  logic                     adv;
  logic                     res_valid;
  logic                     res_was_test;
  logic                     res_visible;
  item_t                    item_next;
  logic signed [DATA_W-1:0] cx_sh, cy_sh, cz_sh, w_sh;

  assign adv       = !res_valid || result.ready;
  assign cmd.ready = adv;

  // Keep only the low COORD_WIDTH bits of coordinates and offset, sign extended.
  always_comb begin
    cx_sh = cmd.center_x <<< CSH;
    cy_sh = cmd.center_y <<< CSH;
    cz_sh = cmd.center_z <<< CSH;
    w_sh  = cmd.plane_offset <<< CSH;
    item_next.operation    = op_t'(cmd.operation);
    item_next.plane_index  = cmd.plane_index;
    item_next.normal_x     = cmd.normal_x;
    item_next.normal_y     = cmd.normal_y;
    item_next.normal_z     = cmd.normal_z;
    item_next.plane_offset = w_sh >>> CSH;
    item_next.center_x     = cx_sh >>> CSH;
    item_next.center_y     = cy_sh >>> CSH;
    item_next.center_z     = cz_sh >>> CSH;
    item_next.extent_x     = cmd.extent_x & EXT_MASK;
    item_next.extent_y     = cmd.extent_y & EXT_MASK;
    item_next.extent_z     = cmd.extent_z & EXT_MASK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0].valid <= cmd.valid;
      chain[0].vis   <= 1'b1;
      chain[0].item  <= item_next;
    end
  end

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
    afct_cell #(
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .lane_in  (chain[i]),
      .lane_out (chain[i+1])
    );
  end

  for (genvar i = 0; i <= PLANE_COUNT; i++) begin : g_valid
    assign lane_valid[i] = chain[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid    <= chain[PLANE_COUNT].valid;
      res_was_test <= (chain[PLANE_COUNT].item.operation == OP_TEST);
      res_visible  <= (chain[PLANE_COUNT].item.operation == OP_TEST)
                      && chain[PLANE_COUNT].vis;
    end
  end

  assign result.valid    = res_valid;
  assign result.was_test = res_was_test;
  assign result.visible  = res_visible;

  `AFCT_ASSERT(a_load_not_visible, clk, rst, result.valid && !result.was_test |-> !result.visible, "load result marked visible")
  `AFCT_ASSERT(a_chain_holds, clk, rst, !adv |=> $stable(lane_valid), "cell chain moved while stalled")
  `AFCT_ASSERT_ALWAYS(a_result_from_chain, clk, adv && !rst |=> result.valid == $past(lane_valid[PLANE_COUNT]), "result valid lost from chain end")

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the box versus frustum plane culling block.
module tb_top;
  import afct_pkg::*;

  localparam int PLANES = 6;
  localparam int PIPE_DEPTH = 2 * PLANES + 2;
  localparam int Q30_ONE = 32'sh4000_0000;
  localparam int S32_MAX = 32'sh7FFF_FFFF;
  localparam int S32_MIN = 32'sh8000_0000;
  localparam logic [EXT_W-1:0] EXT_MAX = '1;

  typedef struct packed {
    logic was_test;
    logic visible;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit steady = 1'b0;
  int error_count = 0;
  plane_t plane_copy [PLANES];
  verdict_t pending_verdicts [$];

  afct_cmd_if cmd();
  afct_result_if result();

  aabb_frustum_cull_test #(
    .PLANE_COUNT(PLANES),
    .COORD_WIDTH(DATA_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Exact sum per plane: radius + distance, offset lifted from Q16.16 to Q18.46.
  function automatic logic box_survives(item_t it);
    logic signed [71:0] total;
    longint cx, cy, cz, ex, ey, ez, nx, ny, nz, w, term;
    cx = $signed(it.center_x);
    cy = $signed(it.center_y);
    cz = $signed(it.center_z);
    ex = longint'(it.extent_x);
    ey = longint'(it.extent_y);
    ez = longint'(it.extent_z);
    for (int p = 0; p < PLANES; p++) begin
      nx = $signed(plane_copy[p].nx);
      ny = $signed(plane_copy[p].ny);
      nz = $signed(plane_copy[p].nz);
      w = $signed(plane_copy[p].w);
      total = '0;
      term = (nx < 0 ? -nx : nx) * ex;
      total = total + term;
      term = (ny < 0 ? -ny : ny) * ey;
      total = total + term;
      term = (nz < 0 ? -nz : nz) * ez;
      total = total + term;
      term = nx * cx;
      total = total + term;
      term = ny * cy;
      total = total + term;
      term = nz * cz;
      total = total + term;
      term = w * (longint'(1) <<< OFFSET_SHIFT);
      total = total + term;
      if (total < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic verdict_t apply_item(item_t it);
    verdict_t v;
    if (it.operation == OP_LOAD) begin
      // Drop loads aimed past the last plane slot.
      if (it.plane_index < PLANES) begin
        plane_copy[it.plane_index] = '{nx: it.normal_x, ny: it.normal_y,
                                       nz: it.normal_z, w: it.plane_offset};
      end
      v.was_test = 1'b0;
      v.visible = 1'b0;
    end else begin
      v.was_test = 1'b1;
      v.visible = box_survives(it);
    end
    return v;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin : track
    item_t seen;
    verdict_t want;
    if (rst) begin
      foreach (plane_copy[p]) plane_copy[p] = '0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        seen.operation = op_t'(cmd.operation);
        seen.plane_index = cmd.plane_index;
        seen.normal_x = cmd.normal_x;
        seen.normal_y = cmd.normal_y;
        seen.normal_z = cmd.normal_z;
        seen.plane_offset = cmd.plane_offset;
        seen.center_x = cmd.center_x;
        seen.center_y = cmd.center_y;
        seen.center_z = cmd.center_z;
        seen.extent_x = cmd.extent_x;
        seen.extent_y = cmd.extent_y;
        seen.extent_z = cmd.extent_z;
        pending_verdicts = {pending_verdicts, apply_item(seen)};
      end
      if (result.valid && result.ready) begin
        if (pending_verdicts.size() == 0) begin
          report_error($sformatf("unexpected result was_test=%0b visible=%0b",
                                 result.was_test, result.visible));
        end else begin
          want = pending_verdicts.pop_front();
          if (result.was_test !== want.was_test) begin
            report_error($sformatf("was_test expected %0b got %0b",
                                   want.was_test, result.was_test));
          end
          if (result.visible !== want.visible) begin
            report_error($sformatf("visible expected %0b got %0b (was_test %0b)",
                                   want.visible, result.visible, want.was_test));
          end
        end
      end
    end
  end

  // Result side: stall at random unless a steady stretch is running.
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result.ready <= steady || ($urandom_range(99) >= 20);
    end
  end

  task automatic drive_item(input item_t it, input logic vld);
    cmd.valid <= vld;
    cmd.operation <= it.operation;
    cmd.plane_index <= it.plane_index;
    cmd.normal_x <= it.normal_x;
    cmd.normal_y <= it.normal_y;
    cmd.normal_z <= it.normal_z;
    cmd.plane_offset <= it.plane_offset;
    cmd.center_x <= it.center_x;
    cmd.center_y <= it.center_y;
    cmd.center_z <= it.center_z;
    cmd.extent_x <= it.extent_x;
    cmd.extent_y <= it.extent_y;
    cmd.extent_z <= it.extent_z;
  endtask

  task automatic send_item(input item_t it);
    if (!steady) begin
      while ($urandom_range(99) < 20) begin
        cmd.valid <= 1'b0;
        @(posedge clk);
      end
    end
    drive_item(it, 1'b1);
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic item_t random_item();
    item_t it;
    it.operation = op_t'($urandom_range(1));
    it.plane_index = IDX_W'($urandom_range(7));
    it.normal_x = $urandom;
    it.normal_y = $urandom;
    it.normal_z = $urandom;
    it.plane_offset = $urandom;
    it.center_x = $urandom;
    it.center_y = $urandom;
    it.center_z = $urandom;
    it.extent_x = EXT_W'($urandom);
    it.extent_y = EXT_W'($urandom);
    it.extent_z = EXT_W'($urandom);
    return it;
  endfunction

  // Box fields of a load and plane fields of a test carry noise.
  function automatic item_t load_item(input int slot, input int nx, input int ny,
                                      input int nz, input int w);
    item_t it;
    it = random_item();
    it.operation = OP_LOAD;
    it.plane_index = IDX_W'(slot);
    it.normal_x = nx;
    it.normal_y = ny;
    it.normal_z = nz;
    it.plane_offset = w;
    return it;
  endfunction

  function automatic item_t box_item(input int cx, input int cy, input int cz,
                                     input logic [EXT_W-1:0] ex,
                                     input logic [EXT_W-1:0] ey,
                                     input logic [EXT_W-1:0] ez);
    item_t it;
    it = random_item();
    it.operation = OP_TEST;
    it.center_x = cx;
    it.center_y = cy;
    it.center_z = cz;
    it.extent_x = ex;
    it.extent_y = ey;
    it.extent_z = ez;
    return it;
  endfunction

  // All planes are zero after reset, so any box is visible.
  task automatic test_empty_table();
    send_item(box_item(S32_MAX, S32_MAX, S32_MAX, '0, '0, '0));
    send_item(box_item(S32_MIN, S32_MIN, S32_MIN, EXT_MAX, EXT_MAX, EXT_MAX));
  endtask

  // Face exactly on the plane stays visible; one LSB past it is culled.
  task automatic test_exact_touch();
    send_item(load_item(0, Q30_ONE, 0, 0, 32'h0001_0000));
    send_item(box_item(-32'h0001_8000, 0, 0, 31'h0000_8000, EXT_MAX, EXT_MAX));
    send_item(box_item(-32'h0001_8001, 0, 0, 31'h0000_8000, EXT_MAX, EXT_MAX));
  endtask

  // Loads to slots past the table must not cull anything.
  task automatic test_unused_slots();
    send_item(load_item(6, Q30_ONE, Q30_ONE, Q30_ONE, S32_MIN));
    send_item(load_item(7, -Q30_ONE, -Q30_ONE, -Q30_ONE, S32_MIN));
    send_item(box_item(0, 0, 0, '0, '0, '0));
  endtask

  task automatic test_extreme_planes();
    send_item(load_item(1, S32_MIN, S32_MIN, S32_MIN, S32_MIN));
    send_item(load_item(2, S32_MAX, S32_MAX, S32_MAX, S32_MAX));
    send_item(box_item(S32_MIN, S32_MIN, S32_MIN, '0, '0, '0));
    send_item(box_item(S32_MAX, S32_MAX, S32_MAX, '0, '0, '0));
    send_item(box_item(S32_MIN, S32_MIN, S32_MIN, EXT_MAX, EXT_MAX, EXT_MAX));
    send_item(box_item(S32_MAX, S32_MAX, S32_MAX, EXT_MAX, EXT_MAX, EXT_MAX));
  endtask

  // Load an axis-aligned frustum (slot 2k faces +axis k, 2k+1 faces -axis k)
  // in shuffled order, then throw boxes around its walls.
  task automatic run_scene(input int boxes, input bit exact);
    int span [3];
    int slots [6];
    int nrm [3];
    int ctr [3];
    int ext [3];
    int pick, tmp, axis, side, gap;
    item_t it;
    for (int k = 0; k < 3; k++) span[k] = $urandom_range(32'h0100_0000, 32'h0001_0000);
    for (int k = 0; k < 6; k++) slots[k] = k;
    for (int k = 5; k > 0; k--) begin
      pick = $urandom_range(k);
      tmp = slots[k];
      slots[k] = slots[pick];
      slots[pick] = tmp;
    end
    foreach (slots[k]) begin
      axis = slots[k] / 2;
      side = (slots[k] % 2) ? -1 : 1;
      for (int a = 0; a < 3; a++) begin
        if (exact) begin
          nrm[a] = (a == axis) ? Q30_ONE : 0;
        end else if (a == axis) begin
          nrm[a] = Q30_ONE + int'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
        end else begin
          nrm[a] = int'($urandom_range(32'h0002_0000)) - 32'h0001_0000;
        end
      end
      gap = exact ? 0 : int'($urandom_range(32'h0000_1000));
      send_item(load_item(slots[k], side * nrm[0], side * nrm[1], side * nrm[2],
                          span[axis] + gap));
    end
    if ($urandom_range(9) == 0) begin
      it = random_item();
      it.operation = OP_LOAD;
      it.plane_index = IDX_W'($urandom_range(7, PLANES));
      send_item(it);
    end
    repeat (boxes) begin
      for (int a = 0; a < 3; a++) begin
        ext[a] = $urandom_range(span[a] / 2);
        ctr[a] = int'($urandom_range(3 * span[a])) - 3 * span[a] / 2;
      end
      if (exact && $urandom_range(3) == 0) begin
        // Put one face on a wall, or one LSB beyond it.
        axis = $urandom_range(2);
        ctr[axis] = span[axis] + ext[axis] + int'($urandom_range(1));
        if ($urandom_range(1)) ctr[axis] = -ctr[axis];
      end
      send_item(box_item(ctr[0], ctr[1], ctr[2],
                         EXT_W'(ext[0]), EXT_W'(ext[1]), EXT_W'(ext[2])));
    end
  endtask

  task automatic test_random_scenes(input int scenes);
    for (int i = 0; i < scenes; i++) begin
      run_scene($urandom_range(44, 20), $urandom_range(1));
      if (i % 6 == 5) wait_drained();
    end
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    run_scene(200, 1'b0);
    steady = 1'b0;
  endtask

  task automatic test_noise(input int count);
    repeat (count) send_item(random_item());
  endtask

  initial begin
    drive_item('0, 1'b0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_exact_touch();
    test_unused_slots();
    test_extreme_planes();
    wait_drained();
    test_random_scenes(24);
    test_steady_stream();
    test_noise(200);
    wait_drained();
    repeat (PIPE_DEPTH + 6) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/afct_pkg.sv
sv/afct_channels.sv
sv/afct_cell.sv
sv/aabb_frustum_cull_test.sv
test/tb_top.sv
